// ===== sv/md5sh_pkg.sv =====
package md5sh_pkg;

    localparam logic [31:0] INIT_A = 32'h67452301;
    localparam logic [31:0] INIT_B = 32'hefcdab89;
    localparam logic [31:0] INIT_C = 32'h98badcfe;
    localparam logic [31:0] INIT_D = 32'h10325476;

    localparam logic [7:0] PAD_MARK  = 8'h80;
    localparam int unsigned LEN_POS  = 56;
    localparam int unsigned ROUNDS   = 64;

    // Per-round additive constants.
    function automatic logic [31:0] round_const(input logic [5:0] r);
        logic [31:0] k;
        begin
            unique case (r)
                6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
                6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
                6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
                6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
                6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
                6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
                6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
                6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
                6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
                6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
                6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
                6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
                6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
                6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
                6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
                6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
                6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
                6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
                6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
                6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
                6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
                6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
                6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
                6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
                6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
                6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
                6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
                6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
                6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
                6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
                6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
                6'd62: k = 32'h2ad7d2bb;  default: k = 32'heb86d391;
            endcase
            return k;
        end
    endfunction

    // Left rotation amount of a round.
    function automatic logic [4:0] rot_amount(input logic [5:0] r);
        logic [4:0] s;
        begin
            unique case ({r[5:4], r[1:0]})
                4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
                4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
                4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
                4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  default: s = 5'd21;
            endcase
            return s;
        end
    endfunction

    // Message word used by a round.
    function automatic logic [3:0] word_index(input logic [5:0] r);
        logic [3:0] g;
        begin
            unique case (r[5:4])
                2'd0:    g = r[3:0];
                2'd1:    g = 4'((r[3:0] << 2) + r[3:0] + 4'd1);
                2'd2:    g = 4'((r[3:0] << 1) + r[3:0] + 4'd5);
                default: g = 4'((r[3:0] << 3) - r[3:0]);
            endcase
            return g;
        end
    endfunction

endpackage

// ===== sv/md5_stream_hasher.sv =====
// MD5 digest engine for a byte stream.
// Input channel (s_*): one message byte per transaction in s_tdata. s_tuser
// says whether the byte belongs to the message; a transaction with s_tuser
// low carries no byte and only serves to close a message with s_tlast.
// s_tlast closes the message after its byte, if any.
// Output channel (m_*): each message gives two transactions of eight digest
// bytes each, first byte in bits 7:0. m_tuser is the half index and m_tlast
// marks the second half.
// Flow: one byte is taken per accepted transfer. The 64th byte of a block starts
// a compression (one read ahead of the block buffer, 64 rounds at one round
// per cycle, then a fold into the chaining words); s_tready is low meanwhile.
// At the end of a message padding writes one byte per cycle up to the block
// end; how long closing takes before the first digest half is offered depends
// on how full the last block is.
// While the digest waits in the output stage the receiver may stall as long
// as it likes; no input is taken until both halves are delivered. Reset
// loads the initial chaining words, clears the bit count and empties both
// channels; the block buffer contents are not cleared.
module md5_stream_hasher (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte
    input  logic        s_tuser,   // byte_valid
    input  logic        s_tlast,   // end_of_message
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // digest_part
    output logic        m_tuser,   // part_index
    output logic        m_tlast    // last_part
);

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_PAD,
        ST_ROUND,
        ST_OUT0,
        ST_OUT1
    } state_t;

    state_t      state_reg;
    logic [31:0] ch_a_reg, ch_b_reg, ch_c_reg, ch_d_reg;
    logic [63:0] bit_total_reg;
    logic [63:0] len_reg;
    logic [31:0] a_reg, b_reg, c_reg, d_reg;
    logic [6:0]  cnt_reg;
    logic [5:0]  pad_ptr_reg;
    logic        pad_first_reg;
    logic        len_fits_reg;
    logic        pad_pending_reg;
    logic        final_reg;

    // Block buffer: sixteen little-endian words with byte-lane writes.
    logic [31:0] blk_mem [16];
    logic [31:0] rd_data_reg;
    logic        wr_en;
    logic [5:0]  wr_pos;
    logic [7:0]  wr_byte;
    logic [3:0]  rd_addr;

    logic        in_acc;
    logic [63:0] bit_total_next;
    logic [5:0]  byte_pos;
    logic [5:0]  round_idx;
    logic [31:0] f_val, t_val, rot_val;
    logic [4:0]  rot_s;
    logic [7:0]  pad_byte;

    assign s_tready = (state_reg == ST_LOAD);
    assign in_acc   = s_tvalid && s_tready;
    assign byte_pos = bit_total_reg[8:3];
    assign bit_total_next = s_tuser ? bit_total_reg + 64'd8 : bit_total_reg;

    assign m_tvalid = (state_reg == ST_OUT0) || (state_reg == ST_OUT1);
    assign m_tuser  = (state_reg == ST_OUT1);
    assign m_tlast  = (state_reg == ST_OUT1);
    assign m_tdata  = (state_reg == ST_OUT1) ? {ch_d_reg, ch_c_reg} : {ch_b_reg, ch_a_reg};

    // The padding byte: the marker first, the length in the last eight bytes of
    // the block that carries it, zeros elsewhere.
    always_comb begin
        if (pad_first_reg) begin
            pad_byte = md5sh_pkg::PAD_MARK;
        end else if (len_fits_reg && (pad_ptr_reg >= 6'(md5sh_pkg::LEN_POS))) begin
            pad_byte = len_reg[{pad_ptr_reg[2:0], 3'b000} +: 8];
        end else begin
            pad_byte = 8'h00;
        end
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_pos  = pad_ptr_reg;
        wr_byte = pad_byte;
        if (in_acc && s_tuser) begin
            wr_en   = 1'b1;
            wr_pos  = byte_pos;
            wr_byte = s_tdata;
        end else if (state_reg == ST_PAD) begin
            wr_en = 1'b1;
        end
    end

    // Reads are registered: each word is fetched in the cycle before the round that consumes it.
    assign rd_addr   = md5sh_pkg::word_index(cnt_reg[5:0]);
    assign round_idx = cnt_reg[5:0] - 6'd1;
    assign rot_s     = md5sh_pkg::rot_amount(round_idx);

    always_comb begin
        unique case (round_idx[5:4])
            2'd0:    f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            2'd1:    f_val = (d_reg & b_reg) | (~d_reg & c_reg);
            2'd2:    f_val = b_reg ^ c_reg ^ d_reg;
            default: f_val = c_reg ^ (b_reg | ~d_reg);
        endcase
        t_val   = a_reg + f_val + md5sh_pkg::round_const(round_idx) + rd_data_reg;
        rot_val = (t_val << rot_s) | (t_val >> (6'd32 - {1'b0, rot_s}));
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            blk_mem[wr_pos[5:2]][{wr_pos[1:0], 3'b000} +: 8] <= wr_byte;
        end
        rd_data_reg <= blk_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_LOAD;
            ch_a_reg        <= md5sh_pkg::INIT_A;
            ch_b_reg        <= md5sh_pkg::INIT_B;
            ch_c_reg        <= md5sh_pkg::INIT_C;
            ch_d_reg        <= md5sh_pkg::INIT_D;
            bit_total_reg   <= 64'd0;
            cnt_reg         <= 7'd0;
            pad_pending_reg <= 1'b0;
            final_reg       <= 1'b0;
            pad_first_reg   <= 1'b0;
            len_fits_reg    <= 1'b0;
            pad_ptr_reg     <= 6'd0;
        end else begin
            unique case (state_reg)
                ST_LOAD: begin
                    if (in_acc) begin
                        bit_total_reg <= bit_total_next;
                        if (s_tlast) begin
                            len_reg         <= bit_total_next;
                            pad_ptr_reg     <= bit_total_next[8:3];
                            pad_first_reg   <= 1'b1;
                            len_fits_reg    <= bit_total_next[8:3] < 6'(md5sh_pkg::LEN_POS);
                        end
                        if (s_tuser && (byte_pos == 6'd63)) begin
                            state_reg       <= ST_ROUND;
                            cnt_reg         <= 7'd0;
                            a_reg           <= ch_a_reg;
                            b_reg           <= ch_b_reg;
                            c_reg           <= ch_c_reg;
                            d_reg           <= ch_d_reg;
                            pad_pending_reg <= s_tlast;
                            final_reg       <= 1'b0;
                        end else if (s_tlast) begin
                            state_reg <= ST_PAD;
                        end
                    end
                end
                ST_PAD: begin
                    pad_first_reg <= 1'b0;
                    pad_ptr_reg   <= pad_ptr_reg + 6'd1;
                    if (pad_ptr_reg == 6'd63) begin
                        state_reg       <= ST_ROUND;
                        cnt_reg         <= 7'd0;
                        a_reg           <= ch_a_reg;
                        b_reg           <= ch_b_reg;
                        c_reg           <= ch_c_reg;
                        d_reg           <= ch_d_reg;
                        final_reg       <= len_fits_reg;
                        pad_pending_reg <= !len_fits_reg;
                        len_fits_reg    <= 1'b1;
                    end
                end
                ST_ROUND: begin
                    cnt_reg <= cnt_reg + 7'd1;
                    if (cnt_reg == 7'(md5sh_pkg::ROUNDS + 1)) begin
                        ch_a_reg <= ch_a_reg + a_reg;
                        ch_b_reg <= ch_b_reg + b_reg;
                        ch_c_reg <= ch_c_reg + c_reg;
                        ch_d_reg <= ch_d_reg + d_reg;
                        if (final_reg) begin
                            state_reg <= ST_OUT0;
                        end else if (pad_pending_reg) begin
                            state_reg <= ST_PAD;
                        end else begin
                            state_reg <= ST_LOAD;
                        end
                    end else if (cnt_reg != 7'd0) begin
                        a_reg <= d_reg;
                        d_reg <= c_reg;
                        c_reg <= b_reg;
                        b_reg <= b_reg + rot_val;
                    end
                end
                ST_OUT0: begin
                    if (m_tready) begin
                        state_reg <= ST_OUT1;
                    end
                end
                ST_OUT1: begin
                    if (m_tready) begin
                        state_reg     <= ST_LOAD;
                        ch_a_reg      <= md5sh_pkg::INIT_A;
                        ch_b_reg      <= md5sh_pkg::INIT_B;
                        ch_c_reg      <= md5sh_pkg::INIT_C;
                        ch_d_reg      <= md5sh_pkg::INIT_D;
                        bit_total_reg <= 64'd0;
                    end
                end
                default: state_reg <= ST_LOAD;
            endcase
        end
    end

    // The round counter never runs past the fold cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ROUND) |-> (cnt_reg <= 7'(md5sh_pkg::ROUNDS + 1)))
        else $error("round counter overran");

    // A digest on offer blocks the input side.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input taken while digest pending");

    // Delivering the second half restarts the message state.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=>
            (bit_total_reg == 64'd0 && ch_a_reg == md5sh_pkg::INIT_A && s_tready))
        else $error("state not reinitialized after digest");

    // The first half is always followed by the second.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tlast) |=> (m_tvalid && m_tlast))
        else $error("second digest half missing");

endmodule
